/* hw/rtl/qpu_pkg.sv */
`default_nettype none

package qpu_pkg;

    // Scan phase
    typedef enum logic [1:0] {
        PH_DONE   = 2'd0,
        PH_SEEK   = 2'd1,
        PH_INSIDE = 2'd2,
        PH_ESCAPE = 2'd3
    } t_phase;

    // Result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CHAR   = 2'd0;
    localparam t_kind KIND_CLOSED = 2'd1;
    localparam t_kind KIND_UNTERM = 2'd2;
    localparam t_kind KIND_NOTQ   = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_V  = 8'h76;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_LOW_N: r = CH_LF;
            CH_LOW_T: r = CH_TAB;
            CH_LOW_R: r = CH_CR;
            CH_LOW_F: r = CH_FF;
            CH_LOW_V: r = CH_VT;
            default:  r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/quoted_parameter_unescaper.sv */
`default_nettype none

// Quoted parameter unescaper: takes text one byte per request on the slave
// stream (tuser flags the first byte of a new scan), skips leading blanks,
// recognizes an opener ([ { ' or ") and emits the unescaped bytes up to the
// matching closer, followed by one status result (closed, unterminated on a
// zero byte, or not quoted). Bytes that arrive after a scan has ended and
// before the next first byte are dropped without a result. The phase and
// closer registers update in the same cycle the byte is accepted, and the
// result lands in a single output register, so a new byte is taken every
// cycle while the master side keeps up. The input stalls only while a
// result sits in the output register and is not taken.
module quoted_parameter_unescaper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  wire logic [0:0] s_axis_tuser,   // [0] first_byte
    // master stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic [1:0]      m_axis_tuser    // [1:0] kind
);

    qpu_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_close, n_close;

    logic            r_out_valid;
    logic [7:0]      r_out_char;
    qpu_pkg::t_kind  r_out_kind;

    logic            w_accept;
    qpu_pkg::t_phase w_cur;       // phase seen by this byte
    logic            w_emit;
    logic [7:0]      w_char;
    qpu_pkg::t_kind  w_kind;
    logic [7:0]      w_byte;

    assign w_byte = s_axis_tdata;

    // Take a new request whenever the output register is empty or drains now.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // A first byte restarts the scan whatever the phase.
    assign w_cur = s_axis_tuser[0] ? qpu_pkg::PH_SEEK : r_phase;

    // Next state: phase and the closer chosen by the opener.
    always_comb begin
        n_phase = w_cur;
        n_close = r_close;
        case (w_cur)
            qpu_pkg::PH_SEEK: begin
                if (!qpu_pkg::is_blank(w_byte)) begin
                    n_phase = qpu_pkg::PH_INSIDE;
                    case (w_byte)
                        qpu_pkg::CH_LBRACK: n_close = qpu_pkg::CH_RBRACK;
                        qpu_pkg::CH_LBRACE: n_close = qpu_pkg::CH_RBRACE;
                        qpu_pkg::CH_SQUOTE: n_close = qpu_pkg::CH_SQUOTE;
                        qpu_pkg::CH_DQUOTE: n_close = qpu_pkg::CH_DQUOTE;
                        default:            n_phase = qpu_pkg::PH_DONE;
                    endcase
                end
            end
            qpu_pkg::PH_INSIDE: begin
                if (w_byte == qpu_pkg::CH_NUL || w_byte == r_close) begin
                    n_phase = qpu_pkg::PH_DONE;
                end else if (w_byte == qpu_pkg::CH_BSLASH) begin
                    n_phase = qpu_pkg::PH_ESCAPE;
                end
            end
            qpu_pkg::PH_ESCAPE: begin
                // escaped closer is plain data; zero still ends the scan
                n_phase = (w_byte == qpu_pkg::CH_NUL) ? qpu_pkg::PH_DONE
                                                      : qpu_pkg::PH_INSIDE;
            end
            default: begin
                n_phase = qpu_pkg::PH_DONE;
            end
        endcase
    end

    // Result for this byte, if any.
    always_comb begin
        w_emit = 1'b0;
        w_char = qpu_pkg::CH_NUL;
        w_kind = qpu_pkg::KIND_CHAR;
        case (w_cur)
            qpu_pkg::PH_SEEK: begin
                if (!qpu_pkg::is_blank(w_byte) &&
                    w_byte != qpu_pkg::CH_LBRACK && w_byte != qpu_pkg::CH_LBRACE &&
                    w_byte != qpu_pkg::CH_SQUOTE && w_byte != qpu_pkg::CH_DQUOTE) begin
                    w_emit = 1'b1;
                    w_kind = qpu_pkg::KIND_NOTQ;
                end
            end
            qpu_pkg::PH_INSIDE: begin
                if (w_byte == qpu_pkg::CH_NUL) begin
                    w_emit = 1'b1;
                    w_kind = qpu_pkg::KIND_UNTERM;
                end else if (w_byte == r_close) begin
                    w_emit = 1'b1;
                    w_kind = qpu_pkg::KIND_CLOSED;
                end else if (w_byte != qpu_pkg::CH_BSLASH) begin
                    w_emit = 1'b1;
                    w_char = w_byte;
                end
            end
            qpu_pkg::PH_ESCAPE: begin
                w_emit = 1'b1;
                if (w_byte == qpu_pkg::CH_NUL) begin
                    w_kind = qpu_pkg::KIND_UNTERM;
                end else begin
                    w_char = qpu_pkg::unescape(w_byte);
                end
            end
            default: begin
                w_emit = 1'b0;   // drop bytes after the end
            end
        endcase
    end

    // Control state: advance only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= qpu_pkg::PH_DONE;
            r_close     <= qpu_pkg::CH_NUL;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_close <= n_close;
            end
            if (w_accept) begin
                r_out_valid <= w_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: load with each accepted request, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_char <= w_char;
            r_out_kind <= w_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = r_out_kind;

endmodule

`default_nettype wire

/* hw/rtl/qpu_checker.sv */
`default_nettype none

module qpu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic [0:0] s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser
);

    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status results carry no character.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != qpu_pkg::KIND_CHAR |->
            m_axis_tdata == qpu_pkg::CH_NUL)
        else $error("status result with nonzero character");

    // A first byte that is blank or an opener gives no result.
    a_first_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tuser[0] &&
        (s_axis_tdata == qpu_pkg::CH_SPACE || s_axis_tdata == qpu_pkg::CH_LBRACK ||
         s_axis_tdata == qpu_pkg::CH_DQUOTE) |=> !m_axis_tvalid)
        else $error("result after blank or opener first byte");

    // A first byte that is a plain letter ends the scan as not quoted.
    a_first_notq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && s_axis_tuser[0] && s_axis_tdata == qpu_pkg::CH_LOW_N |=>
            m_axis_tvalid && m_axis_tuser == qpu_pkg::KIND_NOTQ)
        else $error("missing not-quoted result");

endmodule

bind quoted_parameter_unescaper qpu_checker u_qpu_checker (.*);

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpu_pkg::*;

    // Run limit: a hard stop meant to lie far beyond any legal run, even
    // with both sides idling most of the time.
    localparam int CYCLE_LIMIT    = 300000;
    // One output register: this tail lets the last result drain.
    localparam int TAIL_CYCLES    = 20;
    // Bytes per random phase that the block actually scans (ignored ones excluded).
    localparam int LIVE_PER_PHASE = 260;

    // One decoded result: character plus kind.
    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
    } t_decoded;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] text_byte
    logic [0:0] s_axis_tuser  = 1'b0;   // [0] first_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic [1:0] m_axis_tuser;           // [1:0] kind

    quoted_parameter_unescaper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Results the decoder owes us, oldest first.
    t_decoded   pending_results[$];

    // Shadow copy of the scan state.
    t_phase     scan_phase  = PH_DONE;
    logic [7:0] scan_closer = CH_NUL;

    int mismatch_count = 0;
    int scanned_bytes  = 0;   // bytes that were not simply dropped
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // 10 ns clock: high half, low half.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop if the handshakes ever lock up.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: stall the master side at the current rate, new choice each cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic blank_byte(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic opener_byte(input logic [7:0] b);
        return (b == CH_LBRACK) || (b == CH_LBRACE) || (b == CH_SQUOTE) || (b == CH_DQUOTE);
    endfunction

    // Control code that an escaped letter stands for; anything else passes.
    function automatic logic [7:0] escape_target(input logic [7:0] b);
        case (b)
            CH_LOW_N: escape_target = CH_LF;
            CH_LOW_T: escape_target = CH_TAB;
            CH_LOW_R: escape_target = CH_CR;
            CH_LOW_F: escape_target = CH_FF;
            CH_LOW_V: escape_target = CH_VT;
            default:  escape_target = b;
        endcase
    endfunction

    // Advance the shadow scan by one accepted byte and queue any result it causes.
    task automatic predict_unescape(input logic [7:0] b, input logic first);
        t_decoded res;
        logic     has_res;
        has_res  = 1'b0;
        res.ch   = CH_NUL;
        res.kind = KIND_CHAR;
        // A first byte restarts the scan whatever the phase.
        if (first)
            scan_phase = PH_SEEK;
        if (scan_phase != PH_DONE)
            scanned_bytes++;
        case (scan_phase)
            PH_SEEK: begin
                case (b)
                    CH_LBRACK: scan_closer = CH_RBRACK;
                    CH_LBRACE: scan_closer = CH_RBRACE;
                    CH_SQUOTE: scan_closer = CH_SQUOTE;
                    CH_DQUOTE: scan_closer = CH_DQUOTE;
                    default:   scan_closer = scan_closer;
                endcase
                if (opener_byte(b)) begin
                    scan_phase = PH_INSIDE;
                end else if (!blank_byte(b)) begin
                    // zero or any other byte before the opener: not quoted
                    scan_phase = PH_DONE;
                    res.kind   = KIND_NOTQ;
                    has_res    = 1'b1;
                end
            end
            PH_INSIDE: begin
                has_res = 1'b1;
                if (b == CH_NUL) begin
                    scan_phase = PH_DONE;
                    res.kind   = KIND_UNTERM;
                end else if (b == scan_closer) begin
                    scan_phase = PH_DONE;
                    res.kind   = KIND_CLOSED;
                end else if (b == CH_BSLASH) begin
                    scan_phase = PH_ESCAPE;
                    has_res    = 1'b0;
                end else begin
                    res.ch = b;
                end
            end
            PH_ESCAPE: begin
                has_res = 1'b1;
                if (b == CH_NUL) begin
                    scan_phase = PH_DONE;
                    res.kind   = KIND_UNTERM;
                end else begin
                    // escaped closer lands here too and does not end the scan
                    scan_phase = PH_INSIDE;
                    res.ch     = escape_target(b);
                end
            end
            default: begin
                // done: drop the byte
            end
        endcase
        if (has_res)
            pending_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Compare every accepted result against the oldest pending one.
    always @(posedge i_clk) begin : check_result
        t_decoded want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {m_axis_tdata, m_axis_tuser}, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch("out_char", m_axis_tdata, want.ch);
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
            end
        end
    end

    // Send one request: idle at the current rate, present the byte at the
    // falling edge, hold it until accepted, then predict.
    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= b;
        s_axis_tuser[0] <= first;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_unescape(b, first);
    endtask

    // Drop valid and hold off until every owed result has come out.
    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? CH_SPACE : CH_TAB + 8'(k - 1);
    endfunction

    // Byte to follow a backslash: mostly the mapped letters, the closer or
    // a backslash, sometimes anything nonzero.
    function automatic logic [7:0] pick_escaped(input logic [7:0] closer);
        case ($urandom_range(7))
            0:       return CH_LOW_N;
            1:       return CH_LOW_T;
            2:       return CH_LOW_R;
            3:       return CH_LOW_F;
            4:       return CH_LOW_V;
            5:       return closer;
            6:       return CH_BSLASH;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // One random scan. Mostly well-formed quoted text with random content;
    // the rest ends early, is not quoted, or is plain noise.
    task automatic send_random_scan();
        int         mode;
        int         count;
        int         i;
        logic [7:0] opener;
        logic [7:0] closer;
        logic [7:0] b;
        logic       lead;
        mode = $urandom_range(99);
        if (mode >= 88) begin
            // noise: random bytes, rarely flagged first
            count = $urandom_range(1, 4);
            for (i = 0; i < count; i++)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(9) == 0);
            return;
        end
        lead  = 1'b1;
        count = $urandom_range(0, 2);
        for (i = 0; i < count; i++) begin
            send_byte(pick_blank(), lead);
            lead = 1'b0;
        end
        if (mode >= 80) begin
            // not quoted: a zero or any byte that is neither blank nor opener
            do b = 8'($urandom_range(0, 255)); while (opener_byte(b) || blank_byte(b));
            if ($urandom_range(1))
                b = CH_NUL;
            send_byte(b, lead);
            return;
        end
        case ($urandom_range(3))
            0:       begin opener = CH_LBRACK; closer = CH_RBRACK; end
            1:       begin opener = CH_LBRACE; closer = CH_RBRACE; end
            2:       begin opener = CH_SQUOTE; closer = CH_SQUOTE; end
            default: begin opener = CH_DQUOTE; closer = CH_DQUOTE; end
        endcase
        send_byte(opener, lead);
        count = $urandom_range(0, 10);
        for (i = 0; i < count; i++) begin
            if ($urandom_range(99) < 20) begin
                send_byte(CH_BSLASH, 1'b0);
                send_byte(pick_escaped(closer), 1'b0);
            end else begin
                do b = 8'($urandom_range(1, 255)); while (b == closer || b == CH_BSLASH);
                send_byte(b, 1'b0);
            end
        end
        if (mode < 62) begin
            send_byte(closer, 1'b0);
        end else if (mode < 68) begin
            send_byte(CH_NUL, 1'b0);
        end else if (mode < 74) begin
            send_byte(CH_BSLASH, 1'b0);
            send_byte(CH_NUL, 1'b0);
        end
        // otherwise leave the scan open; the next first byte restarts it
        if (mode < 68 && $urandom_range(3) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0);   // dropped after the end
    endtask

    // Blanks at both ends of their range, bracket quoting, an escaped closer,
    // the top byte value, then a byte after the end that must be dropped.
    task automatic test_blanks_and_brackets();
        send_byte(CH_SPACE, 1'b1);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LBRACK, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_RBRACK, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(CH_RBRACK, 1'b0);
        send_byte(8'h78, 1'b0);
    endtask

    // Brace quoting with mapped escapes, ending on a zero right after a backslash.
    task automatic test_escapes_to_zero();
        send_byte(CH_LBRACE, 1'b1);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOW_N, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOW_T, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_NUL, 1'b0);
    endtask

    // Remaining escapes inside single quotes, a restart in the middle of the
    // scan, a zero inside quotes, then two scans that are not quoted.
    task automatic test_restart_and_unquoted();
        send_byte(CH_SQUOTE, 1'b1);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOW_F, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOW_V, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_LOW_R, 1'b0);
        send_byte(CH_DQUOTE, 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_NUL, 1'b1);
        send_byte(8'h40, 1'b1);
    endtask

    // Random scans under one idling setting, then drain before the next.
    task automatic test_random_traffic(input int send_pct, input int stall_pct);
        int start_count;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start_count    = scanned_bytes;
        while (scanned_bytes - start_count < LIVE_PER_PHASE)
            send_random_scan();
        hold_until_drained();
    endtask

    initial begin
        // Hold reset, then release it at a falling edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_blanks_and_brackets();
        test_escapes_to_zero();
        test_restart_and_unquoted();
        hold_until_drained();

        test_random_traffic(0, 0);
        test_random_traffic(79, 0);
        test_random_traffic(0, 79);
        test_random_traffic(10, 10);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
